### src/single_output_interlock_timer_defines.svh
// assertion macros of the interlock timer step module
`ifndef SINGLE_OUTPUT_INTERLOCK_TIMER_DEFINES_SVH
`define SINGLE_OUTPUT_INTERLOCK_TIMER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SOIT_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interlock timer check failed");

// next-cycle implication, disabled during reset
`define SOIT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interlock timer check failed");

`endif

### src/soit_pkg.sv
// types and constants of the single output interlock timer
package soit_pkg;

   localparam int unsigned NUM_OUTPUTS = 5;

   localparam logic [3:0]  NONE_ON          = 4'hF;
   localparam logic [31:0] GUARD_TIME_RST   = 32'd5000;
   localparam logic [31:0] MAX_ON_TIME_RST  = 32'd600000;

   typedef enum logic [1:0] {
      CMD_ON     = 2'd0,
      CMD_OFF    = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_STATUS = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      RC_OK             = 3'd0,
      RC_BAD_CHANNEL    = 3'd1,
      RC_BAD_DURATION   = 3'd2,
      RC_ALREADY_ACTIVE = 3'd3,
      RC_GUARD_ACTIVE   = 3'd4
   } rc_type;

   typedef enum logic [7:0] {
      CSR_GUARD_TIME  = 8'd0,
      CSR_MAX_ON_TIME = 8'd1
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  channel_req;
      logic [31:0] duration_req;
      logic [31:0] now_time;
   } req_word_type;

   typedef struct packed {
      logic [2:0]        result_code;
      logic              switched_off;
      logic signed [3:0] active_output;
      logic [31:0]       on_remaining;
      logic [31:0]       guard_remaining;
   } rsp_word_type;

endpackage

### src/soit_ifs.sv
// channel interfaces of the interlock timer: command, result and register write
interface soit_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [7:0]  channel_req;
   logic [31:0] duration_req;
   logic [31:0] now_time;

   modport source (output valid, cmd, channel_req, duration_req, now_time, input ready);
   modport sink   (input valid, cmd, channel_req, duration_req, now_time, output ready);
endinterface

interface soit_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        result_code;
   logic              switched_off;
   logic signed [3:0] active_output;
   logic [31:0]       on_remaining;
   logic [31:0]       guard_remaining;

   modport source (output valid, result_code, switched_off, active_output, on_remaining,
                   guard_remaining, input ready);
   modport sink   (input valid, result_code, switched_off, active_output, on_remaining,
                   guard_remaining, output ready);
endinterface

interface soit_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

### src/soit_in_reg.sv
// input register of the command channel
module soit_in_reg
   import soit_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   soit_req_if.sink     req_if,
   input  logic         down_ready,
   output logic         stage_valid,
   output req_word_type stage_word
);

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         take;

   assign req_if.ready = !valid_ff || down_ready;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (down_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff.cmd          <= req_if.cmd;
         word_ff.channel_req  <= req_if.channel_req;
         word_ff.duration_req <= req_if.duration_req;
         word_ff.now_time     <= req_if.now_time;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_word  = word_ff;

endmodule

### src/soit_step.sv
// interlock state, configuration registers and the per-word step logic
`include "single_output_interlock_timer_defines.svh"

module soit_step
   import soit_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   soit_csr_if.sink     csr_if,
   input  logic         stage_valid,
   input  req_word_type stage_word,
   input  logic         out_ready,
   output rsp_word_type result
);

   logic [31:0] guard_time_ff;
   logic [31:0] max_on_time_ff;

   logic [3:0]  on_channel_ff;
   logic [3:0]  on_channel_in;
   logic [31:0] on_start_ff;
   logic [31:0] on_start_in;
   logic [31:0] on_length_ff;
   logic [31:0] on_length_in;
   logic        was_ever_off_ff;
   logic        was_ever_off_in;
   logic [31:0] off_stamp_ff;
   logic [31:0] off_stamp_in;

   logic        adv;
   logic        active;
   logic [31:0] on_gone;
   logic [31:0] on_left_cur;
   logic [31:0] guard_gone;
   logic [31:0] guard_left_cur;
   logic        taken;
   logic        offed;
   rc_type      code;

   assign adv    = stage_valid && out_ready;
   assign active = (on_channel_ff != NONE_ON);

   // wrapping elapsed time, then what is left of each span
   assign on_gone        = stage_word.now_time - on_start_ff;
   assign on_left_cur    = (on_gone >= on_length_ff) ? 32'd0 : (on_length_ff - on_gone);
   assign guard_gone     = stage_word.now_time - off_stamp_ff;
   assign guard_left_cur = (guard_gone >= guard_time_ff) ? 32'd0
                                                          : (guard_time_ff - guard_gone);

   // configuration writes
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_time_ff  <= GUARD_TIME_RST;
         max_on_time_ff <= MAX_ON_TIME_RST;
      end else if (csr_if.valid) begin
         unique case (csr_idx_type'(csr_if.index))
            CSR_GUARD_TIME:  guard_time_ff  <= csr_if.wdata;
            CSR_MAX_ON_TIME: max_on_time_ff <= csr_if.wdata;
            default: ;
         endcase
      end
   end

   // next state and result code
   always_comb begin
      on_channel_in   = on_channel_ff;
      on_start_in     = on_start_ff;
      on_length_in    = on_length_ff;
      was_ever_off_in = was_ever_off_ff;
      off_stamp_in    = off_stamp_ff;
      code            = RC_OK;
      taken           = 1'b0;
      offed           = 1'b0;
      unique case (cmd_type'(stage_word.cmd))
         CMD_ON: begin
            priority if (stage_word.channel_req >= 8'(NUM_OUTPUTS)) begin
               code = RC_BAD_CHANNEL;
            end else if (stage_word.duration_req == 32'd0 ||
                         stage_word.duration_req > max_on_time_ff) begin
               code = RC_BAD_DURATION;
            end else if (active) begin
               code = RC_ALREADY_ACTIVE;
            end else if (was_ever_off_ff && guard_left_cur != 32'd0) begin
               code = RC_GUARD_ACTIVE;
            end else begin
               taken         = 1'b1;
               on_channel_in = stage_word.channel_req[3:0];
               on_start_in   = stage_word.now_time;
               on_length_in  = stage_word.duration_req;
            end
         end
         CMD_OFF: begin
            offed = active;
         end
         CMD_TICK: begin
            offed = active && (on_left_cur == 32'd0);
         end
         CMD_STATUS: ;
         default: ;
      endcase
      if (offed) begin
         on_channel_in   = NONE_ON;
         on_start_in     = 32'd0;
         on_length_in    = 32'd0;
         was_ever_off_in = 1'b1;
         off_stamp_in    = stage_word.now_time;
      end
   end

   // status after the step
   always_comb begin
      result.result_code     = code;
      result.switched_off    = offed;
      result.active_output   = $signed(on_channel_in);
      result.on_remaining    = 32'd0;
      result.guard_remaining = 32'd0;
      if (on_channel_in != NONE_ON) begin
         result.on_remaining = taken ? stage_word.duration_req : on_left_cur;
      end else if (was_ever_off_in) begin
         result.guard_remaining = offed ? guard_time_ff : guard_left_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_channel_ff   <= NONE_ON;
         was_ever_off_ff <= 1'b0;
      end else if (adv) begin
         on_channel_ff   <= on_channel_in;
         was_ever_off_ff <= was_ever_off_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         on_start_ff  <= on_start_in;
         on_length_ff <= on_length_in;
         off_stamp_ff <= off_stamp_in;
      end
   end

   `SOIT_ASSERT_NEXT(a_on_taken, clock, reset, adv && taken,
      on_channel_ff == $past(stage_word.channel_req[3:0]))
   `SOIT_ASSERT_NEXT(a_off_marks_guard, clock, reset, adv && offed,
      was_ever_off_ff && on_channel_ff == NONE_ON)
   `SOIT_ASSERT_NOW(a_idle_no_on_time, clock, reset,
      stage_valid && result.active_output == $signed(NONE_ON), result.on_remaining == 32'd0)
   `SOIT_ASSERT_NOW(a_busy_no_guard, clock, reset,
      stage_valid && result.active_output != $signed(NONE_ON),
      result.guard_remaining == 32'd0)

endmodule

### src/soit_out_reg.sv
// result register of the response channel
module soit_out_reg
   import soit_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   input  rsp_word_type up_word,
   output logic         up_ready,
   soit_rsp_if.source   rsp_if
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;
   logic         load;

   assign up_ready = !valid_ff || rsp_if.ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= up_word;
      end
   end

   assign rsp_if.valid           = valid_ff;
   assign rsp_if.result_code     = word_ff.result_code;
   assign rsp_if.switched_off    = word_ff.switched_off;
   assign rsp_if.active_output   = word_ff.active_output;
   assign rsp_if.on_remaining    = word_ff.on_remaining;
   assign rsp_if.guard_remaining = word_ff.guard_remaining;

endmodule

### src/single_output_interlock_timer.sv
// a command word is held in the input register, its result word then in the result register
// throughput: one command word per cycle, limited only by the result channel taking words
// the step logic runs once between the input register and the result register
// reset is synchronous and active high: nothing on, no switch-off seen yet,
// guard time 5000 ms and longest on time 600000 ms
module single_output_interlock_timer
   import soit_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   soit_req_if.sink   req_if,
   soit_rsp_if.source rsp_if,
   soit_csr_if.sink   csr_if
);

   // handshake between the input register and the result register
   logic         stage_valid;
   req_word_type stage_word;
   logic         out_ready;
   rsp_word_type step_result;

   // command word lands here first, and the next one is taken whenever
   // the result register can move, so words flow back to back
   soit_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .down_ready  (out_ready),
      .stage_valid (stage_valid),
      .stage_word  (stage_word)
   );

   // interlock state and registers; state only moves when the word is
   // handed on, so each word sees the state its predecessor left behind
   soit_step u_step (
      .clock       (clock),
      .reset       (reset),
      .csr_if      (csr_if),
      .stage_valid (stage_valid),
      .stage_word  (stage_word),
      .out_ready   (out_ready),
      .result      (step_result)
   );

   // result register parts the response side from the command side
   soit_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .up_valid (stage_valid),
      .up_word  (step_result),
      .up_ready (out_ready),
      .rsp_if   (rsp_if)
   );

endmodule

### tb/sv/tb_single_output_interlock_timer.sv
// self-checking testbench of the single output interlock timer, directed script then random words
`timescale 1ns / 1ps

module tb_single_output_interlock_timer;
   import soit_pkg::*;

   // cycles with no word moving on any channel before the run is called dead
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   // length of the long result hold-off that backs the block up
   localparam int unsigned HOLD_OFF_CYCLES = 64;
   localparam int unsigned PHASE_WORDS = 100;

   // one line of the directed script; pinned rows carry a hand-written answer
   typedef struct {
      cmd_type      cmd;
      logic [7:0]   channel_req;
      logic [31:0]  duration_req;
      logic [31:0]  now_time;
      bit           pinned;
      rsp_word_type answer;
   } script_row_type;

   typedef struct {
      bit           pinned;
      rsp_word_type answer;
   } pinned_answer_type;

   logic clock;
   logic reset;

   soit_req_if req_if ();
   soit_rsp_if rsp_if ();
   soit_csr_if csr_if ();

   single_output_interlock_timer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // predictor: own copy of the interlock state and the two registers
   // -------------------------------------------------------------------------
   logic [3:0]  lit_channel;     // channel now on, NONE_ON when dark
   logic [31:0] lit_start;
   logic [31:0] lit_length;
   logic        ever_switched_off;
   logic [31:0] dark_since;
   logic [31:0] guard_span;
   logic [31:0] on_limit;

   rsp_word_type      expected_rsp[$];  // results still owed by the block
   pinned_answer_type pinned_answers[$]; // typed answers of the directed rows
   script_row_type    script[$];

   int unsigned errors;
   int unsigned sender_idle_pct;
   int unsigned recv_idle_pct;
   bit          hold_req;
   int unsigned hold_left;
   int unsigned quiet_cycles;
   logic [31:0] ms_clock;

   // time left of a span started at since, with wrapping subtraction
   function automatic logic [31:0] span_left(logic [31:0] span, logic [31:0] since,
                                             logic [31:0] now);
      logic [31:0] gone;
      gone = now - since;
      return (gone >= span) ? 32'd0 : span - gone;
   endfunction

   // one command word through the interlock; updates the predictor state
   function automatic rsp_word_type interlock_step(req_word_type w);
      rsp_word_type r;
      logic         busy;
      logic         turn_off;
      r        = '0;
      busy     = (lit_channel != NONE_ON);
      turn_off = 1'b0;
      r.result_code = RC_OK;
      case (cmd_type'(w.cmd))
         CMD_ON: begin
            // checks in priority order: channel, duration, busy, guard
            if (w.channel_req >= NUM_OUTPUTS)
               r.result_code = RC_BAD_CHANNEL;
            else if (w.duration_req == 32'd0 || w.duration_req > on_limit)
               r.result_code = RC_BAD_DURATION;
            else if (busy)
               r.result_code = RC_ALREADY_ACTIVE;
            else if (ever_switched_off && span_left(guard_span, dark_since, w.now_time) != 0)
               r.result_code = RC_GUARD_ACTIVE;
            else begin
               lit_channel = w.channel_req[3:0];
               lit_start   = w.now_time;
               lit_length  = w.duration_req;
            end
         end
         CMD_OFF:  turn_off = busy;
         CMD_TICK: turn_off = busy && span_left(lit_length, lit_start, w.now_time) == 0;
         default: ;
      endcase
      if (turn_off) begin
         lit_channel       = NONE_ON;
         lit_start         = '0;
         lit_length        = '0;
         ever_switched_off = 1'b1;
         dark_since        = w.now_time;
         r.switched_off    = 1'b1;
      end
      r.active_output = lit_channel;
      if (lit_channel != NONE_ON)
         r.on_remaining = span_left(lit_length, lit_start, w.now_time);
      else if (ever_switched_off)
         r.guard_remaining = span_left(guard_span, dark_since, w.now_time);
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // -------------------------------------------------------------------------
   // monitor: all three channels sampled at the rising edge, before any update
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_word_type      got;
      rsp_word_type      want;
      rsp_word_type      predicted;
      req_word_type      cmd_word;
      pinned_answer_type pa;
      if (reset) begin
         lit_channel       = NONE_ON;
         lit_start         = '0;
         lit_length        = '0;
         ever_switched_off = 1'b0;
         dark_since        = '0;
         guard_span        = GUARD_TIME_RST;
         on_limit          = MAX_ON_TIME_RST;
      end else begin
         // result word leaving the block
         if (rsp_if.valid && rsp_if.ready) begin
            got.result_code     = rsp_if.result_code;
            got.switched_off    = rsp_if.switched_off;
            got.active_output   = rsp_if.active_output;
            got.on_remaining    = rsp_if.on_remaining;
            got.guard_remaining = rsp_if.guard_remaining;
            if (expected_rsp.size() == 0) begin
               $display("%0t: result word with none expected, actual %0h", $time, got);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("result_code", want.result_code, got.result_code);
               check_field("switched_off", want.switched_off, got.switched_off);
               check_field("active_output", want.active_output, got.active_output);
               check_field("on_remaining", want.on_remaining, got.on_remaining);
               check_field("guard_remaining", want.guard_remaining, got.guard_remaining);
            end
         end
         // command word entering the block
         if (req_if.valid && req_if.ready) begin
            cmd_word.cmd          = req_if.cmd;
            cmd_word.channel_req  = req_if.channel_req;
            cmd_word.duration_req = req_if.duration_req;
            cmd_word.now_time     = req_if.now_time;
            predicted = interlock_step(cmd_word);
            // directed rows come first, so their answers line up in order
            if (pinned_answers.size() != 0) begin
               pa = pinned_answers.pop_front();
               expected_rsp.push_back(pa.pinned ? pa.answer : predicted);
            end else
               expected_rsp.push_back(predicted);
         end
         // register write
         if (csr_if.valid && csr_if.ready) begin
            case (csr_idx_type'(csr_if.index))
               CSR_GUARD_TIME:  guard_span = csr_if.wdata;
               CSR_MAX_ON_TIME: on_limit   = csr_if.wdata;
               default: ;
            endcase
         end
      end
   end

   // watchdog: counts cycles in which no word moves anywhere
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // result receiver: random stalls, plus a long hold-off when asked for
   initial begin
      rsp_if.ready = 1'b0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------

   // present one command word, with random sender gaps ahead of it
   task automatic offer_word(input req_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.cmd          <= w.cmd;
      req_if.channel_req  <= w.channel_req;
      req_if.duration_req <= w.duration_req;
      req_if.now_time     <= w.now_time;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [31:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= value;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering and wait until every owed result word has come back
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      // a little margin after the last result word
      repeat (3) @(posedge clock);
   endtask

   function automatic void add_row(cmd_type c, logic [7:0] ch, logic [31:0] dur,
                                   logic [31:0] now, bit pin, rc_type rc, logic off,
                                   logic [3:0] act, logic [31:0] on_rem,
                                   logic [31:0] guard_rem);
      script_row_type row;
      row.cmd                    = c;
      row.channel_req            = ch;
      row.duration_req           = dur;
      row.now_time               = now;
      row.pinned                 = pin;
      row.answer.result_code     = rc;
      row.answer.switched_off    = off;
      row.answer.active_output   = act;
      row.answer.on_remaining    = on_rem;
      row.answer.guard_remaining = guard_rem;
      script.push_back(row);
   endfunction

   // random command words; mostly a slowly advancing clock so on periods
   // and guard periods actually run out, with the odd jump and raw noise word
   task automatic run_random_words(int unsigned count);
      req_word_type w;
      int unsigned  pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            w.cmd          = cmd_type'($urandom_range(3));
            w.channel_req  = 8'($urandom_range(255));
            w.duration_req = $urandom;
            w.now_time     = $urandom;
         end else begin
            ms_clock = ms_clock + $urandom_range(0, 120);
            if ($urandom_range(19) == 0)
               ms_clock = $urandom;
            w.now_time = ms_clock;
            pick = $urandom_range(99);
            if (pick < 40)
               w.cmd = CMD_ON;
            else if (pick < 50)
               w.cmd = CMD_OFF;
            else if (pick < 85)
               w.cmd = CMD_TICK;
            else
               w.cmd = CMD_STATUS;
            w.channel_req = ($urandom_range(9) == 0) ? 8'($urandom_range(5, 255))
                                                     : 8'($urandom_range(0, NUM_OUTPUTS - 1));
            case ($urandom_range(9))
               0:       w.duration_req = 32'd0;
               1:       w.duration_req = on_limit;
               2:       w.duration_req = on_limit + 32'd1;
               3:       w.duration_req = $urandom;
               default: w.duration_req = $urandom_range(1, 300);
            endcase
         end
         offer_word(w);
      end
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      req_word_type      w;
      pinned_answer_type pa;
      logic [31:0]       phase_guard[6];
      logic [31:0]       phase_max_on[6];

      // every input known from time zero
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.cmd          = CMD_STATUS;
      req_if.channel_req  = '0;
      req_if.duration_req = '0;
      req_if.now_time     = '0;
      csr_if.valid        = 1'b0;
      csr_if.index        = CSR_GUARD_TIME;
      csr_if.wdata        = '0;
      errors              = 0;
      hold_req            = 1'b0;
      quiet_cycles        = 0;
      ms_clock            = '0;
      sender_idle_pct     = 27;
      recv_idle_pct       = 80;

      // register settings per random phase, extremes included
      phase_guard  = '{32'd100, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd30, 32'd400};
      phase_max_on = '{32'd500, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd300, 32'd200};

      // directed script under the reset settings (guard 5000, longest on 600000)
      // status, off and tick on a dark block
      add_row(CMD_STATUS, 8'd0, 32'd0, 32'd0, 1, RC_OK, 0, NONE_ON, 0, 0);
      add_row(CMD_OFF, 8'd0, 32'd0, 32'd10, 1, RC_OK, 0, NONE_ON, 0, 0);
      add_row(CMD_TICK, 8'd0, 32'd0, 32'd20, 1, RC_OK, 0, NONE_ON, 0, 0);
      // channel is checked ahead of duration
      add_row(CMD_ON, 8'd5, 32'd100, 32'd30, 1, RC_BAD_CHANNEL, 0, NONE_ON, 0, 0);
      add_row(CMD_ON, 8'd255, 32'd0, 32'd40, 1, RC_BAD_CHANNEL, 0, NONE_ON, 0, 0);
      // zero, just over the limit, all ones
      add_row(CMD_ON, 8'd0, 32'd0, 32'd50, 1, RC_BAD_DURATION, 0, NONE_ON, 0, 0);
      add_row(CMD_ON, 8'd4, 32'd600001, 32'd60, 1, RC_BAD_DURATION, 0, NONE_ON, 0, 0);
      add_row(CMD_ON, 8'd4, 32'hFFFF_FFFF, 32'd70, 1, RC_BAD_DURATION, 0, NONE_ON, 0, 0);
      // top channel at the longest duration, no guard before the first switch-off
      add_row(CMD_ON, 8'd4, 32'd600000, 32'd100, 1, RC_OK, 0, 4'd4, 600000, 0);
      add_row(CMD_ON, 8'd0, 32'd1, 32'd200, 1, RC_ALREADY_ACTIVE, 0, 4'd4, 599900, 0);
      add_row(CMD_TICK, 8'd0, 32'd0, 32'd300, 1, RC_OK, 0, 4'd4, 599800, 0);
      add_row(CMD_OFF, 8'd0, 32'd0, 32'd1000, 1, RC_OK, 1, NONE_ON, 0, 5000);
      // guard running, then just expired
      add_row(CMD_ON, 8'd1, 32'd10, 32'd2000, 1, RC_GUARD_ACTIVE, 0, NONE_ON, 0, 4000);
      add_row(CMD_ON, 8'd1, 32'd10, 32'd6000, 1, RC_OK, 0, 4'd1, 10, 0);
      // tick one short of the end, then on the end
      add_row(CMD_TICK, 8'd0, 32'd0, 32'd6009, 1, RC_OK, 0, 4'd1, 1, 0);
      add_row(CMD_TICK, 8'd0, 32'd0, 32'd6010, 1, RC_OK, 1, NONE_ON, 0, 5000);
      // time going backwards and wrapping through zero
      add_row(CMD_STATUS, 8'd0, 32'd0, 32'd6000, 0, RC_OK, 0, NONE_ON, 0, 0);
      add_row(CMD_ON, 8'd2, 32'd20, 32'd6005, 0, RC_OK, 0, NONE_ON, 0, 0);
      add_row(CMD_STATUS, 8'd0, 32'd0, 32'hFFFF_FFF0, 0, RC_OK, 0, NONE_ON, 0, 0);
      add_row(CMD_TICK, 8'd0, 32'd0, 32'h0000_0010, 0, RC_OK, 0, NONE_ON, 0, 0);
      add_row(CMD_ON, 8'd3, 32'd600000, 32'hFFFF_FFFF, 0, RC_OK, 0, NONE_ON, 0, 0);
      add_row(CMD_OFF, 8'd0, 32'd0, 32'h7FFF_FFFF, 0, RC_OK, 0, NONE_ON, 0, 0);
      add_row(CMD_ON, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA, 0, RC_OK, 0, NONE_ON, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: answer queued ahead of each word, taken at acceptance
      foreach (script[i]) begin
         pa.pinned = script[i].pinned;
         pa.answer = script[i].answer;
         pinned_answers.push_back(pa);
         w.cmd          = script[i].cmd;
         w.channel_req  = script[i].channel_req;
         w.duration_req = script[i].duration_req;
         w.now_time     = script[i].now_time;
         offer_word(w);
      end

      // random phases, each with its own register settings
      // idling: sender 27 / receiver 80, then 80 / 27, then none at all
      for (int p = 0; p < 6; p++) begin
         settle();
         write_reg(CSR_GUARD_TIME, phase_guard[p]);
         write_reg(CSR_MAX_ON_TIME, phase_max_on[p]);
         if (p < 2) begin
            sender_idle_pct = 27;
            recv_idle_pct   = 80;
         end else if (p < 4) begin
            sender_idle_pct = 80;
            recv_idle_pct   = 27;
         end else begin
            sender_idle_pct = 0;
            recv_idle_pct   = 0;
         end
         // long receiver hold-off while words keep coming, so the block backs up
         if (p == 4)
            hold_req = 1'b1;
         run_random_words(PHASE_WORDS);
      end

      settle();
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
